@@ rtl/oqsd_pkg.sv @@
// Shared types and constants for the ordered queue search/delete unit.
// No dependencies; every other file but oqsd_ram takes names from here by scope.
`timescale 1ns / 1ps

package oqsd_pkg;

  localparam int KIND_W  = 2;
  localparam int VALUE_W = 32;
  localparam int POS_W   = 4;
  localparam int OCC_W   = 5;

  // Request codes; the fourth code is unused and ignored.
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;       // capture request, clear index and result
    logic rd_next;    // read address is index + 1 instead of index
    logic wr_append;  // write key at the tail
    logic wr_shift;   // write read data at index
    logic idx_inc;    // advance index
    logic set_hit;    // mark ok and latch index as position
    logic count_inc;
    logic count_dec;
    logic res_load;   // move result into the output register
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              count_zero;
    logic              full;
    logic              match;       // read data equals key
    logic              last;        // index is the last stored slot
    logic              shift_more;  // another entry sits above index + 1
  } sts_t;

endpackage

@@ rtl/oqsd_if.sv @@
// Request and result channel interfaces for the ordered queue unit.
// Depends on oqsd_pkg for field widths.
`timescale 1ns / 1ps

interface oqsd_req_if;
  logic                          valid;
  logic                          ready;
  logic [oqsd_pkg::KIND_W-1:0]   kind;
  logic signed [oqsd_pkg::VALUE_W-1:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

interface oqsd_res_if;
  logic                        valid;
  logic                        ready;
  logic                        ok;
  logic [oqsd_pkg::POS_W-1:0]  position;
  logic [oqsd_pkg::OCC_W-1:0]  occupancy;
  logic                        is_empty;

  modport source (output valid, output ok, output position, output occupancy,
                  output is_empty, input ready);
  modport sink   (input valid, input ok, input position, input occupancy,
                  input is_empty, output ready);
endinterface

@@ rtl/oqsd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module oqsd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/oqsd_datapath.sv @@
// Datapath: entry RAM, scan index, count, and result/output registers.
// Depends on oqsd_pkg and oqsd_ram.
`timescale 1ns / 1ps

module oqsd_datapath #(
  parameter int DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  oqsd_pkg::cmd_t                      cmd,
  output oqsd_pkg::sts_t                      sts,
  input  logic [oqsd_pkg::KIND_W-1:0]         req_kind,
  input  logic signed [oqsd_pkg::VALUE_W-1:0] req_value,
  output logic                                res_ok,
  output logic [oqsd_pkg::POS_W-1:0]          res_position,
  output logic [oqsd_pkg::OCC_W-1:0]          res_occupancy,
  output logic                                res_is_empty
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [oqsd_pkg::KIND_W-1:0]  kind;
  logic [oqsd_pkg::VALUE_W-1:0] key;
  logic [IW-1:0]                idx;
  logic [CW-1:0]                count;
  logic                         ok;
  logic [IW-1:0]                pos;

  logic [CW:0]                  idx_ext;
  logic [IW-1:0]                raddr;
  logic [IW-1:0]                waddr;
  logic [oqsd_pkg::VALUE_W-1:0] wdata;
  logic [oqsd_pkg::VALUE_W-1:0] rdata;
  logic [31:0]                  pos_wide;
  logic [31:0]                  count_wide;

  assign idx_ext = (CW + 1)'(idx);
  assign raddr   = cmd.rd_next ? IW'(idx_ext + (CW + 1)'(1)) : idx;
  assign waddr   = cmd.wr_append ? count[IW-1:0] : idx;
  assign wdata   = cmd.wr_append ? key : rdata;

  oqsd_ram #(
    .WIDTH (oqsd_pkg::VALUE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.wr_append | cmd.wr_shift),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    sts.kind       = kind;
    sts.count_zero = (count == '0);
    sts.full       = (count == CW'(DEPTH));
    sts.match      = (rdata == key);
    sts.last       = ((idx_ext + (CW + 1)'(1)) == (CW + 1)'(count));
    sts.shift_more = ((idx_ext + (CW + 1)'(2)) < (CW + 1)'(count));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.count_inc) begin
      count <= count + CW'(1);
    end else if (cmd.count_dec) begin
      count <= count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind <= req_kind;
      key  <= req_value;
      idx  <= '0;
      ok   <= 1'b0;
      pos  <= '0;
    end else begin
      if (cmd.idx_inc) begin
        idx <= idx + IW'(1);
      end
      if (cmd.set_hit) begin
        ok  <= 1'b1;
        pos <= idx;
      end
    end
  end

  assign pos_wide   = 32'(pos);
  assign count_wide = 32'(count);

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_ok        <= ok;
      res_position  <= pos_wide[oqsd_pkg::POS_W-1:0];
      res_occupancy <= count_wide[oqsd_pkg::OCC_W-1:0];
      res_is_empty  <= (count == '0);
    end
  end

endmodule

@@ rtl/oqsd_ctrl.sv @@
// Controller: sequences insert, scan and shift, and owns the output valid.
// Depends on oqsd_pkg.
`timescale 1ns / 1ps

module oqsd_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  oqsd_pkg::sts_t sts,
  output oqsd_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_DISPATCH, S_INSERT, S_READ, S_COMPARE, S_SHIFT_RD, S_SHIFT_WR, S_FINISH
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts.kind == oqsd_pkg::KIND_INSERT) begin
          state_next = S_INSERT;
        end else if ((sts.kind == oqsd_pkg::KIND_SEARCH ||
                      sts.kind == oqsd_pkg::KIND_DELETE) && !sts.count_zero) begin
          state_next = S_READ;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_INSERT: begin
        if (!sts.full) begin
          cmd.wr_append = 1'b1;
          cmd.count_inc = 1'b1;
          cmd.set_hit   = 1'b1;
        end
        state_next = S_FINISH;
      end
      S_READ: begin
        state_next = S_COMPARE;
      end
      S_COMPARE: begin
        if (sts.match) begin
          cmd.set_hit = 1'b1;
          if (sts.kind == oqsd_pkg::KIND_DELETE) begin
            if (sts.last) begin
              cmd.count_dec = 1'b1;
              state_next    = S_FINISH;
            end else begin
              state_next = S_SHIFT_RD;
            end
          end else begin
            state_next = S_FINISH;
          end
        end else if (sts.last) begin
          state_next = S_FINISH;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_READ;
        end
      end
      S_SHIFT_RD: begin
        cmd.rd_next = 1'b1;
        state_next  = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        cmd.wr_shift = 1'b1;
        cmd.idx_inc  = 1'b1;
        if (sts.shift_more) begin
          state_next = S_SHIFT_RD;
        end else begin
          cmd.count_dec = 1'b1;
          state_next    = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/ordered_queue_search_delete_unit.sv @@
// Top level of the ordered queue search/delete unit.
// Depends on oqsd_pkg, oqsd_if, oqsd_ctrl and oqsd_datapath.
`timescale 1ns / 1ps

// Bounded queue of signed 32-bit values kept in arrival order. Each request
// gives exactly one result. Insert appends at the tail (ok low when full);
// search reports the first match from the head; delete removes the first
// match and closes the gap. Every result carries occupancy and an empty flag.
// Requests are handled one at a time. Entries live in a RAM with one read
// port and registered read data, so the scan takes a read state and a
// compare state per entry examined, and the gap-closing shift takes a read
// state and a write state for every entry above the match that moves down.
// The next request is taken while the previous result still waits in the
// output register. No clearing pass runs after reset; only slots below the
// occupancy are ever read.

module ordered_queue_search_delete_unit #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  oqsd_req_if.sink    req,
  oqsd_res_if.source  res
);

  oqsd_pkg::cmd_t cmd;
  oqsd_pkg::sts_t sts;

  // Sequence each request through dispatch, insert or scan and shift, and finish.
  oqsd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Hold entries, count, scan index and the output register.
  oqsd_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .req_kind      (req.kind),
    .req_value     (req.value),
    .res_ok        (res.ok),
    .res_position  (res.position),
    .res_occupancy (res.occupancy),
    .res_is_empty  (res.is_empty)
  );

endmodule

@@ rtl/oqsd_checker.sv @@
// Port-level checker for the ordered queue unit, bound to the top level.
// Depends on oqsd_pkg for field widths.
`timescale 1ns / 1ps

module oqsd_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       req_valid,
  input logic                       req_ready,
  input logic                       res_valid,
  input logic                       res_ready,
  input logic                       res_ok,
  input logic [oqsd_pkg::POS_W-1:0] res_position,
  input logic [oqsd_pkg::OCC_W-1:0] res_occupancy,
  input logic                       res_is_empty
);

  // A stalled result holds its valid and payload.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_ok) &&
      $stable(res_position) && $stable(res_occupancy) && $stable(res_is_empty))
    else $error("stalled result changed");

  // One request at a time: ready drops right after an acceptance.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("second request taken while one is in progress");

  // Empty flag agrees with occupancy.
  a_empty_occ: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_is_empty == (res_occupancy == '0)))
    else $error("empty flag disagrees with occupancy");

  // A failed request reports position zero.
  a_miss_pos: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ok |-> res_position == '0)
    else $error("nonzero position on a failed request");

endmodule

bind ordered_queue_search_delete_unit oqsd_checker u_oqsd_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .res_valid     (res.valid),
  .res_ready     (res.ready),
  .res_ok        (res.ok),
  .res_position  (res.position),
  .res_occupancy (res.occupancy),
  .res_is_empty  (res.is_empty)
);

@@ tb/tb_ordered_queue_search_delete_unit.sv @@
// Self-checking testbench for the ordered queue search/delete unit.
// Depends on oqsd_pkg, oqsd_if and the RTL top ordered_queue_search_delete_unit.
`timescale 1ns / 1ps

module tb_ordered_queue_search_delete_unit;

  localparam int QUEUE_DEPTH = 16;
  localparam logic [oqsd_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 4000;     // cycles with no handshake on either channel
  localparam int HOLD_CYCLES = 400;      // long receiver hold-off for the pressure test
  localparam int DRAIN_CYCLES = 100;     // settle time after the last result
  localparam int MAX_REPORTS = 10;

  localparam logic signed [oqsd_pkg::VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [oqsd_pkg::VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic                       ok;
    logic [oqsd_pkg::POS_W-1:0] position;
    logic [oqsd_pkg::OCC_W-1:0] occupancy;
    logic                       is_empty;
  } queue_result_t;

  logic clk = 1'b0;
  logic rst;

  oqsd_req_if req_ch ();
  oqsd_res_if res_ch ();

  ordered_queue_search_delete_unit #(
    .DEPTH(QUEUE_DEPTH)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .res(res_ch)
  );

  // Free-running clock, 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the queue, advanced once per accepted request.
  logic signed [oqsd_pkg::VALUE_W-1:0] shadow_slots [QUEUE_DEPTH];
  int                                  shadow_count;

  // Results owed by the block, oldest first.
  queue_result_t pending_results [$];

  int mismatches;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_request;

  // Compute the result of one request and advance the shadow queue.
  function automatic queue_result_t queue_predict(
    input logic [oqsd_pkg::KIND_W-1:0]         kind,
    input logic signed [oqsd_pkg::VALUE_W-1:0] value
  );
    queue_result_t r;
    int            hit;
    r   = '0;
    hit = -1;
    if (kind == oqsd_pkg::KIND_SEARCH || kind == oqsd_pkg::KIND_DELETE) begin
      // first match nearest the head wins
      for (int i = shadow_count - 1; i >= 0; i--) begin
        if (shadow_slots[i] == value) hit = i;
      end
    end
    case (kind)
      oqsd_pkg::KIND_INSERT: begin
        // a full queue refuses the insert and keeps its occupancy
        if (shadow_count < QUEUE_DEPTH) begin
          shadow_slots[shadow_count] = value;
          shadow_count++;
          r.ok = 1'b1;
        end
      end
      oqsd_pkg::KIND_SEARCH: begin
        if (hit >= 0) begin
          r.ok       = 1'b1;
          r.position = hit[oqsd_pkg::POS_W-1:0];
        end
      end
      oqsd_pkg::KIND_DELETE: begin
        if (hit >= 0) begin
          r.ok       = 1'b1;
          r.position = hit[oqsd_pkg::POS_W-1:0];
          // close the gap, keeping arrival order
          for (int i = hit; i < shadow_count - 1; i++) shadow_slots[i] = shadow_slots[i + 1];
          shadow_count--;
        end
      end
      default: ;  // unused code: no state change, ok and position stay low
    endcase
    r.occupancy = shadow_count[oqsd_pkg::OCC_W-1:0];
    r.is_empty  = (shadow_count == 0);
    return r;
  endfunction

  // Offer one request; return at the edge where it is accepted.
  // Valid is left high so back-to-back requests never toggle it within a step.
  task automatic offer_request(input logic [oqsd_pkg::KIND_W-1:0]         kind,
                               input logic signed [oqsd_pkg::VALUE_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.kind  <= kind;
    req_ch.value <= value;
    do @(posedge clk); while (!req_ch.ready);
    pending_results.push_back(queue_predict(kind, value));
  endtask

  // Pick a value: mostly from a small pool or the live contents, so that
  // searches and deletes hit often and duplicates pile up.
  function automatic logic signed [oqsd_pkg::VALUE_W-1:0] pick_value();
    int sel;
    sel = $urandom_range(99);
    if (sel < 30 && shadow_count > 0) return shadow_slots[$urandom_range(shadow_count - 1)];
    if (sel < 65) begin
      case ($urandom_range(5))
        0: return VAL_MIN;
        1: return VAL_MAX;
        2: return 32'sd0;
        3: return -32'sd1;
        default: return $signed(32'($urandom_range(7)));
      endcase
    end
    return $signed($urandom());
  endfunction

  // Pick a request type, steering occupancy so the queue swings
  // between empty and full.
  function automatic logic [oqsd_pkg::KIND_W-1:0] pick_kind();
    int sel;
    int insert_pct;
    sel        = $urandom_range(99);
    insert_pct = (shadow_count < 4) ? 60 : (shadow_count > 12) ? 30 : 42;
    if (sel < 3) return KIND_UNUSED;
    if (sel < 3 + insert_pct) return oqsd_pkg::KIND_INSERT;
    if (sel < 3 + insert_pct + 25) return oqsd_pkg::KIND_SEARCH;
    return oqsd_pkg::KIND_DELETE;
  endfunction

  // Receiver: random ready, plus a long counted hold-off on request.
  int hold_left;
  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Check every accepted result against the oldest expectation.
  always @(posedge clk) begin
    queue_result_t want;
    queue_result_t got;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got = '{res_ch.ok, res_ch.position, res_ch.occupancy, res_ch.is_empty};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("[%0t] unexpected result ok=%0b pos=%0d occ=%0d empty=%0b", $realtime,
                   got.ok, got.position, got.occupancy, got.is_empty);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display({"[%0t] result mismatch: expected ok=%0b pos=%0d occ=%0d empty=%0b,",
                      " got ok=%0b pos=%0d occ=%0d empty=%0b"},
                     $realtime, want.ok, want.position, want.occupancy, want.is_empty,
                     got.ok, got.position, got.occupancy, got.is_empty);
        end
      end
    end
  end

  // Watchdog: end the run if neither channel moves for too long.
  int quiet_cycles;
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Search, delete and the unused code on an empty queue.
  task automatic test_empty_queue();
    offer_request(oqsd_pkg::KIND_SEARCH, 32'sd0);
    offer_request(oqsd_pkg::KIND_DELETE, -32'sd1);
    offer_request(KIND_UNUSED, VAL_MIN);
  endtask

  // Fill to capacity with extremes and duplicates, then overflow once.
  task automatic test_fill_and_overflow();
    logic signed [oqsd_pkg::VALUE_W-1:0] fill [QUEUE_DEPTH];
    fill = '{VAL_MIN, VAL_MAX, 32'sd0, -32'sd1, 32'sd1, 32'sd7, 32'sd7, 32'sh5555_5555,
             32'shAAAA_AAAA, 32'sd100, -32'sd100, 32'sd7, 32'sd42, VAL_MIN + 1,
             VAL_MAX - 1, 32'sd9};
    foreach (fill[i]) offer_request(oqsd_pkg::KIND_INSERT, fill[i]);
    offer_request(oqsd_pkg::KIND_INSERT, 32'sd1234);  // rejected: queue is full
  endtask

  // Hits at head and tail, duplicates, a miss and the unused code, starting from a full queue.
  task automatic test_search_and_delete();
    offer_request(oqsd_pkg::KIND_SEARCH, VAL_MIN);     // head
    offer_request(oqsd_pkg::KIND_SEARCH, 32'sd9);      // tail, top position
    offer_request(oqsd_pkg::KIND_SEARCH, 32'sd7);      // first of three copies
    offer_request(oqsd_pkg::KIND_DELETE, 32'sd7);
    offer_request(oqsd_pkg::KIND_SEARCH, 32'sd7);      // next copy has moved down
    offer_request(oqsd_pkg::KIND_DELETE, 32'sd9);      // tail
    offer_request(oqsd_pkg::KIND_DELETE, 32'sd1234);   // miss
    offer_request(KIND_UNUSED, VAL_MAX);
  endtask

  // Random traffic with the current idle settings.
  task automatic test_random_traffic(input int count);
    for (int n = 0; n < count; n++) offer_request(pick_kind(), pick_value());
  endtask

  // Hold the receiver off while the sender keeps offering, so the block
  // fills its result register and stalls the request side.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request  = HOLD_CYCLES;
    test_random_traffic(50);
  endtask

  initial begin
    rst            = 1'b1;
    req_ch.valid   = 1'b0;
    req_ch.kind    = oqsd_pkg::KIND_INSERT;
    req_ch.value   = '0;
    res_ch.ready   = 1'b0;
    shadow_count   = 0;
    foreach (shadow_slots[i]) shadow_slots[i] = '0;
    mismatches     = 0;
    hold_request   = 0;
    hold_left      = 0;
    quiet_cycles   = 0;
    send_idle_pct  = 9;
    recv_idle_pct  = 77;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, slow receiver.
    test_empty_queue();
    test_fill_and_overflow();
    test_search_and_delete();

    // Random part: slow receiver, then slow sender, then pressure, then full rate.
    test_random_traffic(300);
    send_idle_pct = 77;
    recv_idle_pct = 9;
    test_random_traffic(300);
    test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(300);

    // Drop valid, drain, and let the block settle.
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/oqsd_pkg.sv
rtl/oqsd_if.sv
rtl/oqsd_ram.sv
rtl/oqsd_datapath.sv
rtl/oqsd_ctrl.sv
rtl/ordered_queue_search_delete_unit.sv
rtl/oqsd_checker.sv
tb/tb_ordered_queue_search_delete_unit.sv
